>>> src/tlrf_pkg.sv
package tlrf_pkg;

    // item functions on the input channel
    typedef enum logic [1:0] {
        FUNC_TEXT  = 2'd0,
        FUNC_CMD   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    // result kinds on the output channel
    typedef enum logic [1:0] {
        KIND_READ     = 2'd0,
        KIND_FRAME    = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef struct packed {
        func_t       func;
        logic        source;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  frame_id;
        logic [7:0]  out_byte;
        logic        last;
    } out_item_t;

    // jobs handed from the front to the back
    typedef enum logic [2:0] {
        OP_CHAR,
        OP_LINE,
        OP_OVERFLOW,
        OP_CMD,
        OP_READ
    } op_t;

    // pos: write position for a character, clamped line length for a line end
    typedef struct packed {
        op_t         op;
        logic        src;
        logic [7:0]  pos;
        logic [7:0]  data;
    } job_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_DECIDE,
        ST_COPY,
        ST_LENGTH,
        ST_NOTE,
        ST_CMD,
        ST_READ
    } st_t;

    // frame numbers
    localparam logic [1:0] FID_TEMP = 2'd0;
    localparam logic [1:0] FID_PRI  = 2'd1;
    localparam logic [1:0] FID_SEC  = 2'd2;
    localparam logic [1:0] FID_FUEL = 2'd3;
    localparam int         NUM_FRAMES = 4;

    // control characters
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // line prefixes
    localparam logic [31:0] TAG_PRI  = "PRI:";
    localparam logic [31:0] TAG_SEC  = "SEC:";
    localparam logic [39:0] TAG_FUEL = "FUEL:";
    localparam logic [2:0]  TAG_SHORT_LEN = 3'd4;
    localparam logic [2:0]  TAG_LONG_LEN  = 3'd5;
    localparam int          PFX_N = 5;

    // valid command codes, first code selects the temperature frame
    localparam logic [7:0] CMD_FIRST = 8'h01;
    localparam logic [7:0] CMD_LAST  = 8'h04;

    // job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_W     = 2;

endpackage

>>> src/tlrf_fifo.sv
module tlrf_fifo
    import tlrf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  job_t  push_job,
    output logic  full,
    input  logic  pop,
    output job_t  head,
    output logic  empty
);

    job_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_W:0]     count_reg, count_next;

    assign full  = (count_reg == (QUEUE_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> src/tlrf_front.sv
module tlrf_front
    import tlrf_pkg::*;
#(
    parameter int LINE_MAX    = 256,
    parameter int FRAME_BYTES = 32,
    parameter int NUM_SOURCES = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    input  logic      queue_full,
    output logic      push,
    output job_t      push_job
);

    localparam int LINE_KEEP = FRAME_BYTES + 3;
    localparam int LEN_W     = $clog2(LINE_MAX + 1);
    localparam int SRC_W     = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    logic [LEN_W-1:0] len_reg  [NUM_SOURCES];
    logic [LEN_W-1:0] len_next [NUM_SOURCES];

    logic             take;
    logic             src_ok;
    logic [SRC_W-1:0] sidx;
    logic [LEN_W-1:0] len_cur;
    logic [15:0]      len_wide;

    assign s_ready  = !queue_full;
    assign take     = s_valid && !queue_full;
    assign src_ok   = (NUM_SOURCES > 1) || (s_item.source == 1'b0);
    assign sidx     = src_ok ? SRC_W'(s_item.source) : '0;
    assign len_cur  = len_reg[sidx];
    assign len_wide = 16'(len_cur);

    // classify the transfer and keep the line lengths
    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            len_next[i] = len_reg[i];
        end
        push          = 1'b0;
        push_job.op   = OP_CHAR;
        push_job.src  = s_item.source;
        push_job.pos  = 8'(len_cur);
        push_job.data = s_item.data_byte;
        if (take) begin
            case (s_item.func)
                FUNC_TEXT: begin
                    if (src_ok) begin
                        if (s_item.data_byte == CH_NL) begin
                            push          = 1'b1;
                            push_job.op   = OP_LINE;
                            push_job.pos  = (len_wide > 16'(LINE_KEEP)) ?
                                            8'(LINE_KEEP) : 8'(len_cur);
                            len_next[sidx] = '0;
                        end else if (s_item.data_byte == CH_CR) begin
                            push = 1'b0;
                        end else if (len_cur >= LEN_W'(LINE_MAX)) begin
                            push           = 1'b1;
                            push_job.op    = OP_OVERFLOW;
                            len_next[sidx] = '0;
                        end else begin
                            // characters past the kept head are only counted
                            push           = (len_wide < 16'(LINE_KEEP));
                            push_job.op    = OP_CHAR;
                            len_next[sidx] = len_cur + 1'b1;
                        end
                    end
                end
                FUNC_CMD: begin
                    push        = 1'b1;
                    push_job.op = OP_CMD;
                end
                FUNC_READ: begin
                    push        = 1'b1;
                    push_job.op = OP_READ;
                end
                FUNC_CLEAR: begin
                    if (src_ok) begin
                        len_next[sidx] = '0;
                    end
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                len_reg[i] <= len_next[i];
            end
        end
    end

endmodule

>>> src/tlrf_back.sv
module tlrf_back
    import tlrf_pkg::*;
#(
    parameter int FRAME_BYTES = 32,
    parameter int NUM_SOURCES = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  job_t       q_head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    localparam int TEXT_MAX  = FRAME_BYTES - 2;
    localparam int LINE_KEEP = FRAME_BYTES + 3;
    localparam int KEEP_W    = $clog2(LINE_KEEP);
    localparam int FB_W      = $clog2(FRAME_BYTES);
    localparam int CNT_W     = $clog2(FRAME_BYTES + 1);
    localparam int SRC_W     = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int LN_AW     = SRC_W + KEEP_W;
    localparam int FR_AW     = 2 + FB_W;

    // line heads, frame store and transmit buffer
    logic [7:0]        line_mem  [1 << LN_AW];
    logic [7:0]        frame_mem [1 << FR_AW];
    logic [7:0]        tx_mem    [1 << FB_W];

    logic              ln_we;
    logic [LN_AW-1:0]  ln_waddr, ln_raddr;
    logic [7:0]        ln_wdata, ln_rdata_reg;
    logic              fr_we;
    logic [FR_AW-1:0]  fr_waddr, fr_raddr;
    logic [7:0]        fr_wdata, fr_rdata_reg;
    logic              tx_we;
    logic [FB_W-1:0]   tx_waddr, tx_raddr;
    logic [7:0]        tx_wdata, tx_rdata_reg;

    st_t               state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    job_t              cur_reg, cur_next;
    logic              dly_valid_reg, dly_valid_next;
    logic [FB_W-1:0]   dly_idx_reg, dly_idx_next;
    logic [1:0]        fid_reg, fid_next;
    logic [2:0]        skip_reg, skip_next;
    logic [7:0]        n_reg, n_next;
    kind_t             note_kind_reg, note_kind_next;
    logic [3:0]        fvalid_reg, fvalid_next;
    logic              tx_valid_reg, tx_valid_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic [7:0]        pfx_reg [PFX_N];

    logic              slot_free;
    logic              is_pri, is_sec, is_fuel;
    logic [1:0]        dec_fid;
    logic [2:0]        dec_skip;
    logic [7:0]        dec_rem;
    logic              sel_ok;
    logic [1:0]        sel;

    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;
    assign slot_free = !out_valid_reg || m_ready;

    // prefix match on the first characters of the finished line
    assign is_pri  = (cur_reg.pos >= 8'(TAG_SHORT_LEN)) &&
                     ({pfx_reg[0], pfx_reg[1], pfx_reg[2], pfx_reg[3]} == TAG_PRI);
    assign is_sec  = (cur_reg.pos >= 8'(TAG_SHORT_LEN)) &&
                     ({pfx_reg[0], pfx_reg[1], pfx_reg[2], pfx_reg[3]} == TAG_SEC);
    assign is_fuel = (cur_reg.pos >= 8'(TAG_LONG_LEN)) &&
                     ({pfx_reg[0], pfx_reg[1], pfx_reg[2], pfx_reg[3], pfx_reg[4]}
                      == TAG_FUEL);

    always_comb begin
        if (is_pri) begin
            dec_fid  = FID_PRI;
            dec_skip = TAG_SHORT_LEN;
        end else if (is_sec) begin
            dec_fid  = FID_SEC;
            dec_skip = TAG_SHORT_LEN;
        end else if (is_fuel) begin
            dec_fid  = FID_FUEL;
            dec_skip = TAG_LONG_LEN;
        end else begin
            dec_fid  = FID_TEMP;
            dec_skip = 3'd0;
        end
    end

    assign dec_rem = cur_reg.pos - {5'd0, dec_skip};

    // command code selects a frame, anything else loads zeros
    assign sel_ok = cur_reg.data inside {[CMD_FIRST:CMD_LAST]};
    assign sel    = 2'(cur_reg.data - CMD_FIRST);

    // sequencer: next state, memory ports and result register
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        dly_valid_next = 1'b0;
        dly_idx_next   = dly_idx_reg;
        fid_next       = fid_reg;
        skip_next      = skip_reg;
        n_next         = n_reg;
        note_kind_next = note_kind_reg;
        fvalid_next    = fvalid_reg;
        tx_valid_next  = tx_valid_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        ln_we          = 1'b0;
        ln_waddr       = {SRC_W'(q_head.src), q_head.pos[KEEP_W-1:0]};
        ln_wdata       = q_head.data;
        ln_raddr       = '0;
        fr_we          = 1'b0;
        fr_waddr       = '0;
        fr_wdata       = '0;
        fr_raddr       = '0;
        tx_we          = 1'b0;
        tx_waddr       = '0;
        tx_wdata       = '0;
        tx_raddr       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    pop = 1'b1;
                    case (q_head.op)
                        OP_CHAR: begin
                            ln_we = 1'b1;
                        end
                        OP_LINE: begin
                            cur_next   = q_head;
                            cnt_next   = '0;
                            state_next = ST_PREFIX;
                        end
                        OP_OVERFLOW: begin
                            note_kind_next = KIND_OVERFLOW;
                            fid_next       = FID_TEMP;
                            state_next     = ST_NOTE;
                        end
                        OP_CMD: begin
                            cur_next   = q_head;
                            cnt_next   = '0;
                            state_next = ST_CMD;
                        end
                        OP_READ: begin
                            cnt_next   = '0;
                            state_next = ST_READ;
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end

            // fetch the head characters for the prefix match
            ST_PREFIX: begin
                if (cnt_reg < CNT_W'(PFX_N)) begin
                    ln_raddr       = {SRC_W'(cur_reg.src), KEEP_W'(cnt_reg)};
                    dly_valid_next = 1'b1;
                    dly_idx_next   = FB_W'(cnt_reg);
                    cnt_next       = cnt_reg + 1'b1;
                end else begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                fid_next   = dec_fid;
                skip_next  = dec_skip;
                n_next     = (dec_rem > 8'(TEXT_MAX)) ? 8'(TEXT_MAX) : dec_rem;
                cnt_next   = '0;
                state_next = ST_COPY;
            end

            // copy the text into the frame, zero past its length
            ST_COPY: begin
                if (dly_valid_reg) begin
                    fr_we    = 1'b1;
                    fr_waddr = {fid_reg, dly_idx_reg + 1'b1};
                    fr_wdata = (8'(dly_idx_reg) < n_reg) ? ln_rdata_reg : 8'd0;
                end
                if (cnt_reg < CNT_W'(TEXT_MAX)) begin
                    ln_raddr       = {SRC_W'(cur_reg.src),
                                      KEEP_W'(skip_reg) + KEEP_W'(cnt_reg)};
                    dly_valid_next = 1'b1;
                    dly_idx_next   = FB_W'(cnt_reg);
                    cnt_next       = cnt_reg + 1'b1;
                end else begin
                    state_next = ST_LENGTH;
                end
            end

            ST_LENGTH: begin
                fr_we                = 1'b1;
                fr_waddr             = {fid_reg, FB_W'(0)};
                fr_wdata             = n_reg;
                fvalid_next[fid_reg] = 1'b1;
                note_kind_next       = KIND_FRAME;
                state_next           = ST_NOTE;
            end

            // single event result
            ST_NOTE: begin
                if (slot_free) begin
                    out_valid_next    = 1'b1;
                    out_next.kind     = note_kind_reg;
                    out_next.frame_id = fid_reg;
                    out_next.out_byte = 8'd0;
                    out_next.last     = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            // load the transmit buffer, command code in the last byte
            ST_CMD: begin
                if (dly_valid_reg) begin
                    tx_we    = 1'b1;
                    tx_waddr = dly_idx_reg;
                    tx_wdata = (sel_ok && fvalid_reg[sel]) ? fr_rdata_reg : 8'd0;
                end
                if (cnt_reg < CNT_W'(FRAME_BYTES - 1)) begin
                    fr_raddr       = {sel, FB_W'(cnt_reg)};
                    dly_valid_next = 1'b1;
                    dly_idx_next   = FB_W'(cnt_reg);
                    cnt_next       = cnt_reg + 1'b1;
                end else if (cnt_reg == CNT_W'(FRAME_BYTES - 1)) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    tx_we         = 1'b1;
                    tx_waddr      = FB_W'(FRAME_BYTES - 1);
                    tx_wdata      = cur_reg.data;
                    tx_valid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            // stream the transmit buffer, one byte per free output slot
            ST_READ: begin
                tx_raddr = FB_W'(cnt_reg);
                if (slot_free) begin
                    out_valid_next    = 1'b1;
                    out_next.kind     = KIND_READ;
                    out_next.frame_id = FID_TEMP;
                    out_next.out_byte = tx_valid_reg ? tx_rdata_reg : 8'd0;
                    out_next.last     = (cnt_reg == CNT_W'(FRAME_BYTES - 1));
                    if (cnt_reg == CNT_W'(FRAME_BYTES - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        tx_raddr = FB_W'(cnt_reg + 1'b1);
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dly_valid_reg <= 1'b0;
            fvalid_reg    <= '0;
            tx_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dly_valid_reg <= dly_valid_next;
            fvalid_reg    <= fvalid_next;
            tx_valid_reg  <= tx_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        cur_reg       <= cur_next;
        dly_idx_reg   <= dly_idx_next;
        fid_reg       <= fid_next;
        skip_reg      <= skip_next;
        n_reg         <= n_next;
        note_kind_reg <= note_kind_next;
        out_reg       <= out_next;
        if (state_reg == ST_PREFIX && dly_valid_reg) begin
            pfx_reg[dly_idx_reg[2:0]] <= ln_rdata_reg;
        end
    end

    // memories with registered read data
    always_ff @(posedge aclk) begin
        if (ln_we) begin
            line_mem[ln_waddr] <= ln_wdata;
        end
        ln_rdata_reg <= line_mem[ln_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fr_we) begin
            frame_mem[fr_waddr] <= fr_wdata;
        end
        fr_rdata_reg <= frame_mem[fr_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_waddr] <= tx_wdata;
        end
        tx_rdata_reg <= tx_mem[tx_raddr];
    end

endmodule

>>> src/tagged_line_to_register_frames.sv
// Tagged text lines to register frames.
// Input channel s_valid/s_ready/s_item carries text bytes, command writes,
// read requests and line clears; result channel m_valid/m_ready/m_item
// carries frame-update and overflow events and read data bytes.
// The front classifies each transfer combinationally and tracks line lengths;
// a four-entry job queue feeds the back sequencer, which owns the line,
// frame and transmit memories (one write, one registered read each).
// Text bytes are stored at one per cycle while the sequencer is idle. A newline
// event is built after its job leaves the queue by prefix fetch, a one byte
// per cycle copy through the frame memory port, and the length write.
// A command fills the transmit buffer from the selected frame; a read request
// streams FRAME_BYTES bytes at one per cycle while the receiver is ready.
// Reset (aresetn low, synchronous) empties the queue and line counts and
// marks all frames and the transmit buffer as zero; no clearing pass.
// When the receiver stalls, the result register holds, the sequencer waits
// with a pending result, and the queue keeps taking transfers until it fills.
module tagged_line_to_register_frames
    import tlrf_pkg::*;
#(
    parameter int LINE_MAX    = 256,
    parameter int FRAME_BYTES = 32,
    parameter int NUM_SOURCES = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    logic  push;
    job_t  push_job;
    logic  queue_full;
    logic  pop;
    job_t  q_head;
    logic  q_empty;

    // transfer classification and line bookkeeping
    tlrf_front #(
        .LINE_MAX    (LINE_MAX),
        .FRAME_BYTES (FRAME_BYTES),
        .NUM_SOURCES (NUM_SOURCES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // job queue between front and back
    tlrf_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // memory sequencer and result register
    tlrf_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .NUM_SOURCES (NUM_SOURCES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
